[rtl/leb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants for the LEB128 / zigzag varint decoder.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int unsigned VALUE_W        = 64;
    localparam int unsigned GROUP_W        = 7;
    localparam int unsigned COUNT_W        = 4;
    localparam int unsigned CFG_IDX_W      = 4;
    localparam int unsigned CFG_DATA_W     = 4;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic [COUNT_W-1:0] MAX_GROUPS_RESET = 4'd10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ZIGZAG_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GROUPS  = 4'd1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EOF      = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // One finished value handed from the front end to the back end.
    typedef struct packed {
        logic [VALUE_W-1:0] raw;
        t_status            status;
    } t_entry;

endpackage

[rtl/leb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_front
// Accepts encoded bytes, accumulates 7-bit groups and classifies each byte.
// ----------------------------------------------------------------------------
module leb_front
    import leb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic [COUNT_W-1:0]   i_max_groups,
    output logic                 o_push,
    output t_entry               o_entry
);

    logic [VALUE_W-1:0] r_acc,   n_acc;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [6:0]          w_shift;
    logic [VALUE_W-1:0]  w_merged;
    logic [COUNT_W-1:0]  w_next_count;
    logic                w_cont;

    // Shift of 7 per group; shifts of 64 and more drop the payload.
    assign w_shift      = {r_count, 3'b000} - {3'b000, r_count};
    assign w_merged     = r_acc | ({{(VALUE_W-GROUP_W){1'b0}}, i_byte[6:0]} << w_shift);
    assign w_next_count = r_count + 4'd1;
    assign w_cont       = i_byte[7];

    always_comb begin
        n_acc         = r_acc;
        n_count       = r_count;
        o_push        = 1'b0;
        o_entry.raw   = '0;
        o_entry.status = ST_OK;
        if (i_accept) begin
            if (!w_cont) begin
                o_push         = 1'b1;
                o_entry.raw    = w_merged;
                o_entry.status = ST_OK;
                n_acc          = '0;
                n_count        = '0;
            end else if (w_next_count >= i_max_groups) begin
                o_push         = 1'b1;
                o_entry.status = ST_OVERFLOW;
                n_acc          = '0;
                n_count        = '0;
            end else if (i_last) begin
                o_push         = 1'b1;
                o_entry.status = ST_EOF;
                n_acc          = '0;
                n_count        = '0;
            end else begin
                n_acc   = w_merged;
                n_count = w_next_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
        end else begin
            r_acc   <= n_acc;
            r_count <= n_count;
        end
    end

    // A byte that produces a result always restarts the value.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_count == '0) && (r_acc == '0))
        else $error("front end did not restart after a result");

    // Without a result the group count advances by one.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !o_push) |=> (r_count == $past(r_count) + 4'd1))
        else $error("group count did not advance on a continued byte");

    // A stopping byte is never reported as an error.
    a_ok_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_byte[7]) |-> (o_push && o_entry.status == ST_OK))
        else $error("terminating byte not reported as ok");

endmodule

[rtl/leb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module leb_queue
    import leb_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    t_entry            r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_entry = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_ONE;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_ONE;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_ONE;
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into a full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

endmodule

[rtl/leb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_back
// Applies the zigzag mapping and holds the result in the output register.
// ----------------------------------------------------------------------------
module leb_back
    import leb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_zigzag,
    input  logic                 i_avail,
    input  t_entry               i_entry,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [VALUE_W-1:0]   o_value,
    output t_status              o_status
);

    logic                r_valid, n_valid;
    logic [VALUE_W-1:0]  r_value;
    t_status             r_status;
    logic [VALUE_W-1:0]  w_value;

    assign o_pop = i_avail && (!r_valid || i_ready);

    always_comb begin
        case (i_entry.status)
            ST_OK: begin
                if (i_zigzag) begin
                    w_value = (i_entry.raw >> 1) ^ {VALUE_W{i_entry.raw[0]}};
                end else begin
                    w_value = i_entry.raw;
                end
            end
            default: begin
                w_value = '0;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_value  <= w_value;
            r_status <= i_entry.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

[rtl/leb128_zigzag_decoder_core.sv]
`timescale 1ns / 1ps
// A result word is offered on the master side after the byte completing it is
// accepted (queue write, then output register). Throughput: one byte per cycle
// unless the queue is full; the front end accumulates a 7-bit group per cycle
// and a two-entry queue keeps it running while the output register waits.
// Reset (synchronous, active low) clears the accumulator, the group count, the
// queue and the output valid, sets zigzag mode off and the group limit to 10.
// ----------------------------------------------------------------------------
// leb128_zigzag_decoder_core
// Streaming LEB128 varint decoder with optional zigzag signed mapping.
// ----------------------------------------------------------------------------
module leb128_zigzag_decoder_core
    import leb_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input byte stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,   // end_of_data
    // Decoded result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [VALUE_W-1:0]    m_axis_tdata,   // [63:0] decoded_value
    output logic [1:0]            m_axis_tuser    // [1:0] status
);

    // Configuration registers. The user must write them only while the decoder is
    // idle (the block does not enforce this), so each stage may read them directly.
    logic               r_zigzag;
    logic [COUNT_W-1:0] r_max_groups;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zigzag     <= 1'b0;
            r_max_groups <= MAX_GROUPS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ZIGZAG_MODE) begin
                r_zigzag <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_MAX_GROUPS) begin
                r_max_groups <= i_cfg_data[COUNT_W-1:0];
            end
        end
    end

    // A byte is taken whenever the queue can absorb a possible result word.
    logic    w_accept;
    logic    w_push;
    t_entry  w_push_entry;
    logic    w_q_full;
    logic    w_q_empty;
    t_entry  w_q_entry;
    logic    w_pop;
    t_status w_status;

    assign s_axis_tready = !w_q_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Front end: accumulation of 7-bit groups and end / error classification.
    leb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_byte       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_max_groups (r_max_groups),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    // Queue of finished raw values between the two halves.
    leb_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_entry (w_q_entry)
    );

    // Back end: zigzag mapping, zeroing on error and the output register.
    leb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_zigzag (r_zigzag),
        .i_avail  (!w_q_empty),
        .i_entry  (w_q_entry),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_value  (m_axis_tdata),
        .o_status (w_status)
    );

    assign m_axis_tuser = w_status;

endmodule
